@@ sv/etitp_pkg.sv @@
// Shared types and constants for the efficiency table interpolation block.
// Holds the microcode ROM, the sequencer control types and the field widths.
// No dependencies.
package etitp_pkg;

    localparam int ENTRIES_W  = 7;
    localparam int INDEX_W    = 6;
    localparam int KEY_W      = 16;
    localparam int EFF_W      = 16;
    localparam int TRIAL_W    = 16;
    localparam int S_DATA_W   = 72;
    localparam int M_DATA_W   = 8;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register word index, taken from paddr above the byte lanes.
    localparam logic [0:0] REG_ENTRIES_IN_USE = 1'b0;

    localparam int PROD_W    = 32;
    localparam int DIV_STEPS = 32;
    localparam int DIV_CNT_W = 5;
    localparam int UPC_W     = 3;

    localparam logic [UPC_W-1:0] UPC_ACCEPT   = 3'd0;
    localparam logic [UPC_W-1:0] UPC_FETCH    = 3'd1;
    localparam logic [UPC_W-1:0] UPC_LOADPREV = 3'd2;
    localparam logic [UPC_W-1:0] UPC_SCAN     = 3'd3;
    localparam logic [UPC_W-1:0] UPC_MUL      = 3'd4;
    localparam logic [UPC_W-1:0] UPC_DIV      = 3'd5;
    localparam logic [UPC_W-1:0] UPC_FIN      = 3'd6;
    localparam logic [UPC_W-1:0] UPC_EMIT     = 3'd7;

    typedef enum logic
    {
        ACT_LOAD,
        ACT_QUERY
    } action_t;

    typedef enum logic [2:0]
    {
        UOP_ACCEPT,
        UOP_FETCH,
        UOP_LOADPREV,
        UOP_SCAN,
        UOP_MUL,
        UOP_DIV,
        UOP_FIN,
        UOP_EMIT
    } uop_t;

    typedef enum logic [2:0]
    {
        HOLD_NONE,
        HOLD_IN_VALID,
        HOLD_SCAN,
        HOLD_DIV,
        HOLD_OUT
    } hold_t;

    typedef enum logic [1:0]
    {
        COND_NEVER,
        COND_ALWAYS,
        COND_SKIP,
        COND_MISS
    } cond_t;

    typedef struct packed
    {
        uop_t             uop;
        hold_t            hold;
        cond_t            cond;
        logic [UPC_W-1:0] target;
    } ucode_t;

    typedef struct packed
    {
        logic load;
        logic step;
    } div_ctrl_t;

    // A step first holds while its hold condition is true, then jumps to its
    // target when its jump condition is true, and otherwise falls through.
    function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] pc);
        ucode_t w;
        case (pc)
            UPC_ACCEPT:   w = '{UOP_ACCEPT,   HOLD_IN_VALID, COND_SKIP,   UPC_EMIT};
            UPC_FETCH:    w = '{UOP_FETCH,    HOLD_NONE,     COND_NEVER,  UPC_ACCEPT};
            UPC_LOADPREV: w = '{UOP_LOADPREV, HOLD_NONE,     COND_NEVER,  UPC_ACCEPT};
            UPC_SCAN:     w = '{UOP_SCAN,     HOLD_SCAN,     COND_MISS,   UPC_EMIT};
            UPC_MUL:      w = '{UOP_MUL,      HOLD_NONE,     COND_NEVER,  UPC_ACCEPT};
            UPC_DIV:      w = '{UOP_DIV,      HOLD_DIV,      COND_NEVER,  UPC_ACCEPT};
            UPC_FIN:      w = '{UOP_FIN,      HOLD_NONE,     COND_NEVER,  UPC_ACCEPT};
            UPC_EMIT:     w = '{UOP_EMIT,     HOLD_OUT,      COND_ALWAYS, UPC_ACCEPT};
            default:      w = '{UOP_ACCEPT,   HOLD_IN_VALID, COND_SKIP,   UPC_EMIT};
        endcase
        return w;
    endfunction

endpackage

@@ sv/etitp_table.sv @@
// Key and efficiency table: one write port and one registered read port.
// Depends on etitp_pkg for the field widths.
module etitp_table
    import etitp_pkg::*;
#(
    parameter int TABLE_DEPTH = 64,
    localparam int AW = $clog2(TABLE_DEPTH)
)
(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [KEY_W-1:0] wr_key,
    input  logic [EFF_W-1:0] wr_eff,
    input  logic [AW-1:0]    rd_addr,
    output logic [KEY_W-1:0] rd_key,
    output logic [EFF_W-1:0] rd_eff
);

    logic [KEY_W+EFF_W-1:0] mem [TABLE_DEPTH];
    logic [KEY_W+EFF_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= {wr_key, wr_eff};
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_key = rd_data_reg[KEY_W+EFF_W-1:EFF_W];
    assign rd_eff = rd_data_reg[EFF_W-1:0];

endmodule

@@ sv/etitp_div.sv @@
// Restoring divider, one quotient bit per step, for the interpolation slope.
// Depends on etitp_pkg for the control struct and widths.
module etitp_div
    import etitp_pkg::*;
(
    input  logic              clk,
    input  div_ctrl_t         ctrl,
    input  logic [PROD_W-1:0] dividend,
    input  logic [KEY_W-1:0]  divisor,
    output logic [PROD_W-1:0] quotient
);

    logic [PROD_W-1:0] quo_reg;
    logic [KEY_W-1:0]  rem_reg;
    logic [KEY_W:0]    shifted;
    logic              fits;

    // The remainder stays below the divisor, so the shifted value needs one extra bit.
    assign shifted = {rem_reg, quo_reg[PROD_W-1]};
    assign fits    = shifted >= {1'b0, divisor};

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (ctrl.step)
        begin
            quo_reg <= {quo_reg[PROD_W-2:0], fits};
            if (fits)
            begin
                rem_reg <= KEY_W'(shifted - {1'b0, divisor});
            end
            else
            begin
                rem_reg <= shifted[KEY_W-1:0];
            end
        end
    end

    assign quotient = quo_reg;

endmodule

@@ sv/efficiency_table_interp_trial_core.sv @@
// Channel   Dir  Width  Contents
// s_axis    in   72+1   load entry or photon query (tuser: action)
// m_axis    out  8      detected, in_table
// apb       in   32     entries_in_use register at byte address 0
//
// A load goes from the accept step straight to the emit step, which registers its result.
// A query that finds a pair fetches, loads the previous entry, walks the table pairs, then
// multiplies and runs the divider; one that finds no pair skips the multiply and divide.
// The scan does one memory read per cycle and the divider gives one bit per step.
// Items are processed one at a time; the next item is taken while a result
// still waits in the output register. A stalled output holds the sequencer in
// its emit step. Reset clears control state only; the table needs no clearing.
// Depends on etitp_pkg, etitp_table and etitp_div.
module efficiency_table_interp_trial_core
    import etitp_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // entry_index[5:0], entry_key[21:6], entry_efficiency[37:22],
    // photon_energy[53:38], trial[69:54], zero fill
    input  logic [S_DATA_W-1:0]   s_tdata,
    // action[0]
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // detected[0], in_table[1], zero fill
    output logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int AW = $clog2(TABLE_DEPTH);

    logic [INDEX_W-1:0] entry_index;
    logic [KEY_W-1:0]   entry_key;
    logic [EFF_W-1:0]   entry_efficiency;
    logic [KEY_W-1:0]   photon_energy;
    logic [TRIAL_W-1:0] trial;

    assign entry_index      = s_tdata[5:0];
    assign entry_key        = s_tdata[21:6];
    assign entry_efficiency = s_tdata[37:22];
    assign photon_energy    = s_tdata[53:38];
    assign trial            = s_tdata[69:54];

    logic [UPC_W-1:0]     pc_reg, pc_next;
    logic [ENTRIES_W-1:0] entries_reg, entries_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;
    logic                 det_reg, det_next;
    logic                 hit_reg, hit_next;
    logic                 m_valid_reg, m_valid_next;
    logic                 m_det_reg, m_det_next;
    logic                 m_hit_reg, m_hit_next;

    logic [AW-1:0]      addr_reg;
    logic [AW-1:0]      idx_reg;
    logic [KEY_W-1:0]   energy_reg;
    logic [TRIAL_W-1:0] trial_reg;
    logic [KEY_W-1:0]   prev_key_reg;
    logic [EFF_W-1:0]   prev_eff_reg;
    logic [KEY_W-1:0]   dx_reg;
    logic [EFF_W-1:0]   dy_reg;
    logic               neg_reg;
    logic [KEY_W-1:0]   den_reg;

    ucode_t               uc;
    logic                 is_load;
    logic                 accept;
    logic [ENTRIES_W-1:0] n_eff;
    logic [ENTRIES_W-1:0] n_last;
    logic                 too_short;
    logic                 hit;
    logic                 scan_end;
    logic                 out_free;
    logic                 hold;
    logic                 jump;
    logic                 reg_wr;
    logic                 tbl_wr;
    logic [KEY_W-1:0]     rd_key;
    logic [EFF_W-1:0]     rd_eff;
    div_ctrl_t            div_ctrl;
    logic [PROD_W-1:0]    product;
    logic [PROD_W-1:0]    quotient;
    logic signed [18:0]   interp;
    logic [EFF_W-1:0]     eff_clamped;

    assign uc        = ucode_rom(pc_reg);
    assign is_load   = (s_tuser == ACT_LOAD);
    assign s_tready  = (uc.uop == UOP_ACCEPT);
    assign accept    = s_tvalid && s_tready;

    always_comb
    begin
        if (int'(entries_reg) > TABLE_DEPTH)
        begin
            n_eff = ENTRIES_W'(TABLE_DEPTH);
        end
        else
        begin
            n_eff = entries_reg;
        end
    end

    assign n_last    = n_eff - ENTRIES_W'(1);
    assign too_short = n_eff < ENTRIES_W'(2);
    assign hit       = (prev_key_reg < energy_reg) && (energy_reg < rd_key);
    assign scan_end  = (idx_reg == '0);
    assign out_free  = !m_valid_reg || m_tready;

    assign tbl_wr = accept && is_load && (int'(entry_index) < TABLE_DEPTH);

    etitp_table #(.TABLE_DEPTH(TABLE_DEPTH)) u_table
    (
        .clk     (clk),
        .wr_en   (tbl_wr),
        .wr_addr (AW'(entry_index)),
        .wr_key  (entry_key),
        .wr_eff  (entry_efficiency),
        .rd_addr (addr_reg),
        .rd_key  (rd_key),
        .rd_eff  (rd_eff)
    );

    assign product  = dx_reg * dy_reg;
    assign div_ctrl = '{load: (uc.uop == UOP_MUL), step: (uc.uop == UOP_DIV)};

    etitp_div u_div
    (
        .clk      (clk),
        .ctrl     (div_ctrl),
        .dividend (product),
        .divisor  (den_reg),
        .quotient (quotient)
    );

    // The quotient is below the efficiency span, so 17 bits carry it fully.
    always_comb
    begin
        if (neg_reg)
        begin
            interp = $signed({3'b000, prev_eff_reg}) - $signed({2'b00, quotient[16:0]});
        end
        else
        begin
            interp = $signed({3'b000, prev_eff_reg}) + $signed({2'b00, quotient[16:0]});
        end
        if (interp < 0)
        begin
            eff_clamped = '0;
        end
        else if (interp > 19'sd65535)
        begin
            eff_clamped = '1;
        end
        else
        begin
            eff_clamped = interp[EFF_W-1:0];
        end
    end

    // Sequencer: hold, then conditional jump, else fall through.
    always_comb
    begin
        case (uc.hold)
            HOLD_NONE:     hold = 1'b0;
            HOLD_IN_VALID: hold = !s_tvalid;
            HOLD_SCAN:     hold = !hit && !scan_end;
            HOLD_DIV:      hold = (div_cnt_reg != '0);
            HOLD_OUT:      hold = !out_free;
            default:       hold = 1'b0;
        endcase
        case (uc.cond)
            COND_NEVER:  jump = 1'b0;
            COND_ALWAYS: jump = 1'b1;
            COND_SKIP:   jump = is_load || too_short;
            COND_MISS:   jump = !hit;
            default:     jump = 1'b0;
        endcase
        if (hold)
        begin
            pc_next = pc_reg;
        end
        else if (jump)
        begin
            pc_next = uc.target;
        end
        else
        begin
            pc_next = pc_reg + UPC_W'(1);
        end
    end

    assign reg_wr = psel && penable && pwrite && pready &&
                    (paddr[APB_ADDR_W-1:2] == REG_ENTRIES_IN_USE);

    always_comb
    begin
        entries_next = entries_reg;
        div_cnt_next = div_cnt_reg;
        det_next     = det_reg;
        hit_next     = hit_reg;
        m_valid_next = m_valid_reg;
        m_det_next   = m_det_reg;
        m_hit_next   = m_hit_reg;
        if (reg_wr)
        begin
            entries_next = pwdata[ENTRIES_W-1:0];
        end
        if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
        case (uc.uop)
            UOP_ACCEPT:
            begin
                det_next = 1'b0;
                hit_next = 1'b0;
            end
            UOP_MUL:
            begin
                div_cnt_next = DIV_CNT_W'(DIV_STEPS - 1);
            end
            UOP_DIV:
            begin
                if (div_cnt_reg != '0)
                begin
                    div_cnt_next = div_cnt_reg - DIV_CNT_W'(1);
                end
            end
            UOP_FIN:
            begin
                det_next = (trial_reg <= eff_clamped);
                hit_next = 1'b1;
            end
            UOP_EMIT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_det_next   = det_reg;
                    m_hit_next   = hit_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg      <= UPC_ACCEPT;
            entries_reg <= '0;
            div_cnt_reg <= '0;
            det_reg     <= 1'b0;
            hit_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
            m_det_reg   <= 1'b0;
            m_hit_reg   <= 1'b0;
        end
        else
        begin
            pc_reg      <= pc_next;
            entries_reg <= entries_next;
            div_cnt_reg <= div_cnt_next;
            det_reg     <= det_next;
            hit_reg     <= hit_next;
            m_valid_reg <= m_valid_next;
            m_det_reg   <= m_det_next;
            m_hit_reg   <= m_hit_next;
        end
    end

    // The read address runs one entry ahead of the data register, so the scan
    // compares one new pair every cycle.
    always_ff @(posedge clk)
    begin
        case (uc.uop)
            UOP_ACCEPT:
            begin
                energy_reg <= photon_energy;
                trial_reg  <= trial;
                addr_reg   <= AW'(n_last);
                idx_reg    <= AW'(n_last - ENTRIES_W'(1));
            end
            UOP_FETCH:
            begin
                addr_reg <= addr_reg - AW'(1);
            end
            UOP_LOADPREV:
            begin
                prev_key_reg <= rd_key;
                prev_eff_reg <= rd_eff;
                addr_reg     <= addr_reg - AW'(1);
            end
            UOP_SCAN:
            begin
                if (hit)
                begin
                    dx_reg  <= energy_reg - prev_key_reg;
                    den_reg <= rd_key - prev_key_reg;
                    neg_reg <= rd_eff < prev_eff_reg;
                    if (rd_eff < prev_eff_reg)
                    begin
                        dy_reg <= prev_eff_reg - rd_eff;
                    end
                    else
                    begin
                        dy_reg <= rd_eff - prev_eff_reg;
                    end
                end
                else
                begin
                    prev_key_reg <= rd_key;
                    prev_eff_reg <= rd_eff;
                    addr_reg     <= addr_reg - AW'(1);
                    idx_reg      <= idx_reg - AW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_DATA_W - 2){1'b0}}, m_hit_reg, m_det_reg};
    assign pready   = 1'b1;
    assign prdata   = (paddr[APB_ADDR_W-1:2] == REG_ENTRIES_IN_USE) ?
                      APB_DATA_W'(entries_reg) : '0;

endmodule

@@ sv/etitp_checker.sv @@
// Port-level checks for the efficiency table interpolation block.
// Attached to efficiency_table_interp_trial_core by the bind at the end.
module etitp_checker
    import etitp_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // A result waiting for its transfer stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // Detection is only possible when a bracketing pair was found.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[0] && !m_tdata[1]))
        else $error("detected without a table hit");

    // One item at a time: input is closed in the cycle after a transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second item taken while one is in work");

    // A new result is registered only while the input side is closed.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without an item in work");

endmodule

bind efficiency_table_interp_trial_core etitp_checker u_etitp_checker (.*);
